// File: design/fwbp_pkg.sv
// shared types, constants and helper functions of the framed window base profile
package fwbp_pkg;

    localparam int CHAR_W   = 8;
    localparam int POS_W    = 29;
    localparam int START_W  = 28;
    localparam int CNT_W    = 9;
    localparam int FRAME_W  = 3;
    localparam int BASE_W   = 4;
    localparam int WIN_W    = 9;
    localparam int STEP_W   = 16;
    localparam int PER_W    = 4;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    typedef enum logic [2:0] {
        REG_BASE_SET   = 3'd0,
        REG_WINDOW_LEN = 3'd1,
        REG_STEP_LEN   = 3'd2,
        REG_PERIOD_LEN = 3'd3,
        REG_START_POS  = 3'd4,
        REG_END_POS    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [BASE_W-1:0]  base_set;
        logic [WIN_W-1:0]   window_len;
        logic [STEP_W-1:0]  step_len;
        logic [PER_W-1:0]   period_len;
        logic [START_W-1:0] start_pos;
        logic [START_W-1:0] end_pos;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        base_set:   4'd6,
        window_len: 9'd201,
        step_len:   16'd51,
        period_len: 4'd3,
        start_pos:  28'd0,
        end_pos:    28'hFFFFFFF
    };

    // write strobes that touch the sequence state of the front part
    typedef struct packed {
        logic               period_wr;
        logic               start_wr;
        logic [START_W-1:0] start_val;
    } t_cfg_evt;

    // classified base, the part that does not depend on the parameters
    typedef struct packed {
        logic             match;
        logic             emit;
        logic [POS_W-1:0] centre;
    } t_item_fix;

    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w, input int cap);
        if (w == '0) begin
            eff_window = 9'd1;
        end else if (32'(w) > cap) begin
            eff_window = 9'(cap);
        end else begin
            eff_window = w;
        end
    endfunction

    function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] p, input int cap);
        if (p == '0) begin
            eff_period = 4'd1;
        end else if (32'(p) > cap) begin
            eff_period = 4'(cap);
        end else begin
            eff_period = p;
        end
    endfunction

    function automatic logic is_match(input logic [CHAR_W-1:0] c, input logic [BASE_W-1:0] bs);
        unique case (c)
            CHAR_A:  is_match = bs[0];
            CHAR_C:  is_match = bs[1];
            CHAR_G:  is_match = bs[2];
            CHAR_T:  is_match = bs[3];
            default: is_match = 1'b0;
        endcase
    endfunction

endpackage

// File: design/fwbp_ifs.sv
// stream interfaces for the base input and the profile result output
interface fwbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;

    modport source (output valid, output base_char, input ready);
    modport sink   (input valid, input base_char, output ready);
endinterface

interface fwbp_out_if;
    logic        valid;
    logic        ready;
    logic [28:0] centre_pos;
    logic [2:0]  frame;
    logic [8:0]  count;
    logic        last;

    modport source (output valid, output centre_pos, output frame, output count,
                    output last, input ready);
    modport sink   (input valid, input centre_pos, input frame, input count,
                    input last, output ready);
endinterface

// File: design/fwbp_queue.sv
// short fifo of classified bases between the front and back parts
module fwbp_queue #(
    parameter int DW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_pop
);

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    logic [DW-1:0] r_slot [QD];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
`endif

endmodule

// File: design/fwbp_front.sv
// front part: takes bases, tracks position, ring slot, frame and step, classifies each base
module fwbp_front #(
    parameter  int MAX_WINDOW = 256,
    parameter  int MAX_PERIOD = 8,
    localparam int RIW = $clog2(MAX_WINDOW),
    localparam int FIW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fwbp_in_if.sink              i_in,
    input  fwbp_pkg::t_cfg       i_cfg,
    input  fwbp_pkg::t_cfg_evt   i_evt,
    input  logic                 i_q_full,
    input  logic                 i_clr_busy,
    output logic                 o_push,
    output logic [RIW-1:0]       o_ring_idx,
    output logic [FIW-1:0]       o_frame,
    output fwbp_pkg::t_item_fix  o_fix
);

    localparam int MSW = $clog2(fwbp_pkg::POS_W + 1);

    logic [fwbp_pkg::WIN_W-1:0]  win, half;
    logic [fwbp_pkg::STEP_W-1:0] stp;
    logic [fwbp_pkg::PER_W-1:0]  per;

    logic [RIW-1:0]                r_ring, n_ring, ring_cur;
    logic [RIW:0]                  ring_plus;
    logic [FIW-1:0]                r_frame, n_frame;
    logic [FIW:0]                  frame_plus;
    logic [fwbp_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [fwbp_pkg::POS_W:0]      pos_plus;
    logic [fwbp_pkg::WIN_W-1:0]    r_fill, n_fill, fill_plus;
    logic [fwbp_pkg::STEP_W-1:0]   r_step, n_step;
    logic [fwbp_pkg::STEP_W:0]     step_plus;
    logic                          emit, accept;

    // remainder of position by period, one bit per cycle
    logic                          r_mod_busy, n_mod_busy;
    logic [MSW-1:0]                r_mod_cnt, n_mod_cnt;
    logic [fwbp_pkg::POS_W-1:0]    r_mod_sh, n_mod_sh;
    logic [fwbp_pkg::PER_W-1:0]    r_rem, n_rem;
    logic [fwbp_pkg::PER_W:0]      rem_sh;

    always_comb begin
        win  = fwbp_pkg::eff_window(i_cfg.window_len, MAX_WINDOW);
        per  = fwbp_pkg::eff_period(i_cfg.period_len, MAX_PERIOD);
        stp  = (i_cfg.step_len == '0) ? 16'd1 : i_cfg.step_len;
        half = win >> 1;
    end

    assign i_in.ready = !i_q_full && !r_mod_busy && !i_clr_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && (r_pos <= {1'b0, i_cfg.end_pos});

    always_comb begin
        ring_cur   = (32'(r_ring) >= 32'(win)) ? '0 : r_ring;
        ring_plus  = {1'b0, ring_cur} + 1'b1;
        frame_plus = {1'b0, r_frame} + 1'b1;
        pos_plus   = {1'b0, r_pos} + 1'b1;
        fill_plus  = r_fill + 1'b1;
        step_plus  = {1'b0, r_step} + 1'b1;

        n_ring  = r_ring;
        n_frame = r_frame;
        n_pos   = r_pos;
        n_fill  = r_fill;
        n_step  = r_step;
        emit    = 1'b0;

        if (r_fill < win) begin
            emit = (fill_plus == win);
        end else begin
            emit = (step_plus >= {1'b0, stp});
        end

        if (o_push) begin
            n_ring  = (32'(ring_plus) >= 32'(win)) ? '0 : RIW'(ring_plus);
            n_frame = (32'(frame_plus) >= 32'(per)) ? '0 : FIW'(frame_plus);
            n_pos   = fwbp_pkg::POS_W'(pos_plus);
            if (r_fill < win) begin
                n_fill = fill_plus;
                if (emit) begin
                    n_step = '0;
                end
            end else begin
                n_step = emit ? '0 : fwbp_pkg::STEP_W'(step_plus);
            end
        end

        rem_sh     = {r_rem, r_mod_sh[fwbp_pkg::POS_W-1]};
        n_mod_busy = r_mod_busy;
        n_mod_cnt  = r_mod_cnt;
        n_mod_sh   = r_mod_sh;
        n_rem      = r_rem;
        if (i_evt.period_wr || i_evt.start_wr) begin
            n_mod_busy = 1'b1;
            n_mod_cnt  = MSW'(fwbp_pkg::POS_W);
            n_rem      = '0;
            n_mod_sh   = i_evt.start_wr ? {1'b0, i_evt.start_val} : r_pos;
            if (i_evt.start_wr) begin
                n_pos = {1'b0, i_evt.start_val};
            end
        end else if (r_mod_busy) begin
            n_rem     = (rem_sh >= {1'b0, per}) ? fwbp_pkg::PER_W'(rem_sh - {1'b0, per})
                                                : fwbp_pkg::PER_W'(rem_sh);
            n_mod_sh  = r_mod_sh << 1;
            n_mod_cnt = r_mod_cnt - 1'b1;
            if (r_mod_cnt == MSW'(1)) begin
                n_mod_busy = 1'b0;
                n_frame    = FIW'(n_rem);
            end
        end
    end

    always_comb begin
        o_ring_idx   = ring_cur;
        o_frame      = r_frame;
        o_fix.match  = fwbp_pkg::is_match(i_in.base_char, i_cfg.base_set);
        o_fix.emit   = emit;
        o_fix.centre = (pos_plus >= {21'b0, half}) ?
                       fwbp_pkg::POS_W'(pos_plus - {21'b0, half}) : '0;
    end

    always_ff @(posedge i_clk) begin
        r_mod_sh <= n_mod_sh;
        r_rem    <= n_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring     <= '0;
            r_frame    <= '0;
            r_pos      <= '0;
            r_fill     <= '0;
            r_step     <= '0;
            r_mod_busy <= 1'b0;
            r_mod_cnt  <= '0;
        end else begin
            r_ring     <= n_ring;
            r_frame    <= n_frame;
            r_pos      <= n_pos;
            r_fill     <= n_fill;
            r_step     <= n_step;
            r_mod_busy <= n_mod_busy;
            r_mod_cnt  <= n_mod_cnt;
        end
    end

endmodule

// File: design/fwbp_back.sv
// back part: flag ring memory, per-frame counters and the result burst
module fwbp_back #(
    parameter  int MAX_WINDOW = 256,
    parameter  int MAX_PERIOD = 8,
    localparam int RIW = $clog2(MAX_WINDOW),
    localparam int FIW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fwbp_pkg::t_cfg       i_cfg,
    input  logic                 i_q_valid,
    input  logic [RIW-1:0]       i_ring_idx,
    input  logic [FIW-1:0]       i_frame,
    input  fwbp_pkg::t_item_fix  i_fix,
    output logic                 o_pop,
    output logic                 o_clr_busy,
    fwbp_out_if.source           o_res
);

    logic [fwbp_pkg::PER_W-1:0] per;

    // match flag ring, cleared by a sweep after reset
    logic                r_flags [MAX_WINDOW];
    logic                r_clr_busy;
    logic [RIW-1:0]      r_clr_idx;
    logic                r_rdata;

    // stage holding the base whose flag read is in flight
    logic                r_a_valid;
    logic [RIW-1:0]      r_a_idx;
    logic [FIW-1:0]      r_a_frame;
    fwbp_pkg::t_item_fix r_a_fix;
    logic                r_fwd_hit, r_fwd_val;
    logic                a_load, proc, old_flag, inc, dec;

    logic [fwbp_pkg::CNT_W-1:0] r_cnt  [MAX_PERIOD];
    logic [fwbp_pkg::CNT_W-1:0] n_cnt  [MAX_PERIOD];
    logic [fwbp_pkg::CNT_W-1:0] r_snap [MAX_PERIOD];

    logic                       r_burst_act;
    logic [FIW-1:0]             r_burst_j;
    logic [fwbp_pkg::POS_W-1:0] r_burst_centre;
    logic                       burst_last, out_load;

    logic                       r_out_valid;
    logic [fwbp_pkg::POS_W-1:0] r_out_centre;
    logic [fwbp_pkg::FRAME_W-1:0] r_out_frame;
    logic [fwbp_pkg::CNT_W-1:0] r_out_count;
    logic                       r_out_last;

    assign per        = fwbp_pkg::eff_period(i_cfg.period_len, MAX_PERIOD);
    assign o_clr_busy = r_clr_busy;

    assign burst_last = (32'(r_burst_j) + 1 == 32'(per));
    assign out_load   = r_burst_act && (!r_out_valid || o_res.ready);
    // a base may update the counters once the burst has taken its last snapshot entry
    assign proc       = r_a_valid && (!r_burst_act || (out_load && burst_last));
    assign a_load     = i_q_valid && !r_clr_busy && (!r_a_valid || proc);
    assign o_pop      = a_load;

    assign old_flag = r_fwd_hit ? r_fwd_val : r_rdata;
    assign inc      = r_a_fix.match && !old_flag;
    assign dec      = !r_a_fix.match && old_flag;

    always_comb begin
        for (int k = 0; k < MAX_PERIOD; k++) begin
            n_cnt[k] = r_cnt[k];
            if (proc && (32'(r_a_frame) == k)) begin
                if (inc && (r_cnt[k] != fwbp_pkg::CNT_MAX)) begin
                    n_cnt[k] = r_cnt[k] + 1'b1;
                end else if (dec && (r_cnt[k] != '0)) begin
                    n_cnt[k] = r_cnt[k] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_flags[r_clr_idx] <= 1'b0;
        end else if (proc) begin
            r_flags[r_a_idx] <= r_a_fix.match;
        end
        if (a_load) begin
            r_rdata <= r_flags[i_ring_idx];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_idx   <= i_ring_idx;
            r_a_frame <= i_frame;
            r_a_fix   <= i_fix;
            // the slot written this cycle is read stale by the memory
            r_fwd_hit <= proc && (r_a_idx == i_ring_idx);
            r_fwd_val <= r_a_fix.match;
        end
        if (proc && r_a_fix.emit) begin
            r_burst_centre <= r_a_fix.centre;
            for (int k = 0; k < MAX_PERIOD; k++) begin
                r_snap[k] <= n_cnt[k];
            end
        end else if (out_load) begin
            for (int k = 0; k < MAX_PERIOD - 1; k++) begin
                r_snap[k] <= r_snap[k+1];
            end
        end
        if (out_load) begin
            r_out_centre <= r_burst_centre;
            r_out_frame  <= fwbp_pkg::FRAME_W'(r_burst_j);
            r_out_count  <= r_snap[0];
            r_out_last   <= burst_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_a_valid   <= 1'b0;
            r_burst_act <= 1'b0;
            r_burst_j   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_PERIOD; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == RIW'(MAX_WINDOW - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (a_load) begin
                r_a_valid <= 1'b1;
            end else if (proc) begin
                r_a_valid <= 1'b0;
            end
            for (int k = 0; k < MAX_PERIOD; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
            if (proc && r_a_fix.emit) begin
                r_burst_act <= 1'b1;
                r_burst_j   <= '0;
            end else if (out_load) begin
                r_burst_j <= r_burst_j + 1'b1;
                if (burst_last) begin
                    r_burst_act <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.centre_pos = r_out_centre;
    assign o_res.frame      = r_out_frame;
    assign o_res.count      = r_out_count;
    assign o_res.last       = r_out_last;

`ifndef SYNTHESIS
    a_last_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.last |-> o_res.frame == 3'(per - 4'd1))
        else $error("last result not on final frame");

    a_frame_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && !o_res.last
        |=> o_res.valid && (o_res.frame == 3'($past(o_res.frame) + 3'd1)))
        else $error("burst frame sequence broken");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_a_valid && !r_burst_act)
        else $error("base processed during flag clearing");
`endif

endmodule

// File: design/framed_window_base_profile.sv
// Sliding-window base profile split by reading frame.
// i_base carries one ASCII nucleotide per transfer; o_res carries profile results
// (centre_pos, frame, count, last). An APB port holds the registers base_set,
// window_len, step_len, period_len, start_pos and end_pos at byte address 4*i.
// Throughput is one base per cycle while i_base.ready is high. A base that
// completes the window, and then every step_len-th base, produces a burst of
// period results, one per cycle while o_res is ready, frame 0 first, last set
// on the final one; the front keeps taking bases into a four-entry queue while
// the burst drains. A burst's first result passes the queue, the flag-read
// stage, the burst snapshot and the output register. Bases past end_pos are
// taken and dropped. After reset the flag ring is cleared entry by entry over
// all MAX_WINDOW entries (256 by default); i_base.ready stays low meanwhile.
// A write to period_len or start_pos recomputes the frame by a bit-serial
// remainder sweep, with i_base.ready low. When o_res stalls, the burst holds in
// the output register, the queue fills and i_base.ready drops; nothing is lost.
module framed_window_base_profile #(
    parameter int MAX_WINDOW = 256,
    parameter int MAX_PERIOD = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fwbp_in_if.sink                      i_base,
    fwbp_out_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fwbp_pkg::ADDR_W-1:0]  paddr,
    input  logic [fwbp_pkg::DATA_W-1:0]  pwdata,
    output logic [fwbp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int RIW  = $clog2(MAX_WINDOW);
    localparam int FIW  = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int FXW  = $bits(fwbp_pkg::t_item_fix);
    localparam int QDW  = RIW + FIW + FXW;

    fwbp_pkg::t_cfg      r_cfg;
    fwbp_pkg::t_cfg_evt  evt;
    fwbp_pkg::t_reg_idx  reg_idx;
    logic                wr;

    logic                push, q_full, q_valid, pop, clr_busy;
    logic [RIW-1:0]      f_ring;
    logic [FIW-1:0]      f_frame;
    fwbp_pkg::t_item_fix f_fix;
    logic [QDW-1:0]      q_in, q_out;

    assign pready  = 1'b1;
    assign reg_idx = fwbp_pkg::t_reg_idx'(paddr[4:2]);
    assign wr      = psel && penable && pwrite;

    always_comb begin
        evt.period_wr = wr && (reg_idx == fwbp_pkg::REG_PERIOD_LEN);
        evt.start_wr  = wr && (reg_idx == fwbp_pkg::REG_START_POS);
        evt.start_val = pwdata[fwbp_pkg::START_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fwbp_pkg::CFG_RESET;
        end else if (wr) begin
            unique case (reg_idx)
                fwbp_pkg::REG_BASE_SET:   r_cfg.base_set   <= pwdata[fwbp_pkg::BASE_W-1:0];
                fwbp_pkg::REG_WINDOW_LEN: r_cfg.window_len <= pwdata[fwbp_pkg::WIN_W-1:0];
                fwbp_pkg::REG_STEP_LEN:   r_cfg.step_len   <= pwdata[fwbp_pkg::STEP_W-1:0];
                fwbp_pkg::REG_PERIOD_LEN: r_cfg.period_len <= pwdata[fwbp_pkg::PER_W-1:0];
                fwbp_pkg::REG_START_POS:  r_cfg.start_pos  <= pwdata[fwbp_pkg::START_W-1:0];
                fwbp_pkg::REG_END_POS:    r_cfg.end_pos    <= pwdata[fwbp_pkg::START_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fwbp_pkg::REG_BASE_SET:   prdata = 32'(r_cfg.base_set);
            fwbp_pkg::REG_WINDOW_LEN: prdata = 32'(r_cfg.window_len);
            fwbp_pkg::REG_STEP_LEN:   prdata = 32'(r_cfg.step_len);
            fwbp_pkg::REG_PERIOD_LEN: prdata = 32'(r_cfg.period_len);
            fwbp_pkg::REG_START_POS:  prdata = 32'(r_cfg.start_pos);
            fwbp_pkg::REG_END_POS:    prdata = 32'(r_cfg.end_pos);
            default:                  prdata = '0;
        endcase
    end

    fwbp_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_base),
        .i_cfg      (r_cfg),
        .i_evt      (evt),
        .i_q_full   (q_full),
        .i_clr_busy (clr_busy),
        .o_push     (push),
        .o_ring_idx (f_ring),
        .o_frame    (f_frame),
        .o_fix      (f_fix)
    );

    assign q_in = {f_ring, f_frame, f_fix};

    fwbp_queue #(
        .DW (QDW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (pop)
    );

    fwbp_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_ring_idx (q_out[QDW-1:FIW+FXW]),
        .i_frame    (q_out[FIW+FXW-1:FXW]),
        .i_fix      (fwbp_pkg::t_item_fix'(q_out[FXW-1:0])),
        .o_pop      (pop),
        .o_clr_busy (clr_busy),
        .o_res      (o_res)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// testbench of the framed window base profile: base stream, register setup and frame count scoreboard
module testbench;

    localparam int WIN_CAP       = 256;
    localparam int PER_CAP       = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [fwbp_pkg::CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [fwbp_pkg::CHAR_W-1:0] CHAR_U       = 8'h55;
    localparam logic [fwbp_pkg::CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [fwbp_pkg::CHAR_W-1:0] CHAR_ALL_ONE = 8'hFF;

    typedef struct packed {
        logic [fwbp_pkg::POS_W-1:0]   centre_pos;
        logic [fwbp_pkg::FRAME_W-1:0] frame;
        logic [fwbp_pkg::CNT_W-1:0]   count;
        logic                         last;
    } t_profile;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [fwbp_pkg::ADDR_W-1:0] paddr;
    logic [fwbp_pkg::DATA_W-1:0] pwdata;
    logic [fwbp_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    fwbp_in_if  base_if();
    fwbp_out_if res_if();

    framed_window_base_profile u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (base_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // profile predictor state
    fwbp_pkg::t_cfg             cfg;
    bit                         hit_ring [WIN_CAP];
    logic [fwbp_pkg::CNT_W-1:0] frame_tally [PER_CAP];
    int unsigned                ring_ptr;
    int unsigned                fill_n;
    int unsigned                step_n;
    int unsigned                cur_frame;
    int unsigned                cur_pos;

    t_profile    profile_q [$];
    int unsigned fail_cnt     = 0;
    int unsigned quiet_cycles = 0;
    bit          base_idle_on = 1'b0;
    bit          res_idle_on  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned win_eff();
        if (cfg.window_len == '0) return 1;
        if (cfg.window_len > WIN_CAP) return WIN_CAP;
        return cfg.window_len;
    endfunction

    function automatic int unsigned per_eff();
        if (cfg.period_len == '0) return 1;
        if (cfg.period_len > PER_CAP) return PER_CAP;
        return cfg.period_len;
    endfunction

    function automatic void clear_profile_state();
        cfg = fwbp_pkg::CFG_RESET;
        foreach (hit_ring[i]) hit_ring[i] = 1'b0;
        foreach (frame_tally[i]) frame_tally[i] = '0;
        ring_ptr  = 0;
        fill_n    = 0;
        step_n    = 0;
        cur_pos   = cfg.start_pos;
        cur_frame = cur_pos % per_eff();
    endfunction

    function automatic void apply_reg(input fwbp_pkg::t_reg_idx idx,
                                      input logic [fwbp_pkg::DATA_W-1:0] v);
        case (idx)
            fwbp_pkg::REG_BASE_SET:   cfg.base_set   = v[fwbp_pkg::BASE_W-1:0];
            fwbp_pkg::REG_WINDOW_LEN: cfg.window_len = v[fwbp_pkg::WIN_W-1:0];
            fwbp_pkg::REG_STEP_LEN:   cfg.step_len   = v[fwbp_pkg::STEP_W-1:0];
            fwbp_pkg::REG_PERIOD_LEN: begin
                cfg.period_len = v[fwbp_pkg::PER_W-1:0];
                cur_frame = cur_pos % per_eff();
            end
            fwbp_pkg::REG_START_POS: begin
                cfg.start_pos = v[fwbp_pkg::START_W-1:0];
                cur_pos   = cfg.start_pos;
                cur_frame = cur_pos % per_eff();
            end
            fwbp_pkg::REG_END_POS:    cfg.end_pos    = v[fwbp_pkg::START_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [fwbp_pkg::DATA_W-1:0] reg_mask(input fwbp_pkg::t_reg_idx idx);
        case (idx)
            fwbp_pkg::REG_BASE_SET:
                return {{(fwbp_pkg::DATA_W-fwbp_pkg::BASE_W){1'b0}}, {fwbp_pkg::BASE_W{1'b1}}};
            fwbp_pkg::REG_WINDOW_LEN:
                return {{(fwbp_pkg::DATA_W-fwbp_pkg::WIN_W){1'b0}}, {fwbp_pkg::WIN_W{1'b1}}};
            fwbp_pkg::REG_STEP_LEN:
                return {{(fwbp_pkg::DATA_W-fwbp_pkg::STEP_W){1'b0}}, {fwbp_pkg::STEP_W{1'b1}}};
            fwbp_pkg::REG_PERIOD_LEN:
                return {{(fwbp_pkg::DATA_W-fwbp_pkg::PER_W){1'b0}}, {fwbp_pkg::PER_W{1'b1}}};
            default:
                return {{(fwbp_pkg::DATA_W-fwbp_pkg::START_W){1'b0}},
                        {fwbp_pkg::START_W{1'b1}}};
        endcase
    endfunction

    // one accepted base: update flags and frame counts, queue the burst if a point is due
    function automatic void predict_base(input logic [fwbp_pkg::CHAR_W-1:0] c);
        int unsigned win;
        int unsigned per;
        int unsigned stp;
        int unsigned f;
        int unsigned half;
        int unsigned centre;
        bit          hit;
        bit          emit;
        t_profile    r;
        win  = win_eff();
        per  = per_eff();
        stp  = (cfg.step_len == '0) ? 1 : cfg.step_len;
        emit = 1'b0;
        if (cur_pos > cfg.end_pos) return;
        if (ring_ptr >= win) ring_ptr = 0;
        if (cur_frame >= per) cur_frame = cur_pos % per;
        f = cur_frame;
        case (c)
            fwbp_pkg::CHAR_A: hit = cfg.base_set[0];
            fwbp_pkg::CHAR_C: hit = cfg.base_set[1];
            fwbp_pkg::CHAR_G: hit = cfg.base_set[2];
            fwbp_pkg::CHAR_T: hit = cfg.base_set[3];
            default:          hit = 1'b0;
        endcase
        if (hit && !hit_ring[ring_ptr]) begin
            hit_ring[ring_ptr] = 1'b1;
            if (frame_tally[f] != fwbp_pkg::CNT_MAX) frame_tally[f] = frame_tally[f] + 1'b1;
        end else if (!hit && hit_ring[ring_ptr]) begin
            hit_ring[ring_ptr] = 1'b0;
            if (frame_tally[f] != '0) frame_tally[f] = frame_tally[f] - 1'b1;
        end
        if (fill_n < win) begin
            fill_n++;
            if (fill_n == win) begin
                step_n = 0;
                emit   = 1'b1;
            end
        end else begin
            step_n++;
            if (step_n >= stp) step_n = 0;
            emit = (step_n == 0);
        end
        half   = win / 2;
        centre = (cur_pos + 1 >= half) ? cur_pos + 1 - half : 0;
        ring_ptr++;
        if (ring_ptr >= win) ring_ptr = 0;
        cur_frame++;
        if (cur_frame >= per) cur_frame = 0;
        cur_pos = (cur_pos + 1) & 32'h1FFF_FFFF;
        if (emit) begin
            for (int j = 0; j < per; j++) begin
                r.centre_pos = fwbp_pkg::POS_W'(centre);
                r.frame      = fwbp_pkg::FRAME_W'(j);
                r.count      = frame_tally[j];
                r.last       = (j == per - 1);
                profile_q.push_back(r);
            end
        end
    endfunction

    function automatic logic [fwbp_pkg::CHAR_W-1:0] rand_base();
        if ($urandom_range(99) >= 85) return fwbp_pkg::CHAR_W'($urandom_range(255));
        case ($urandom_range(3))
            0:       return fwbp_pkg::CHAR_A;
            1:       return fwbp_pkg::CHAR_C;
            2:       return fwbp_pkg::CHAR_G;
            default: return fwbp_pkg::CHAR_T;
        endcase
    endfunction

    task automatic apb_access(input fwbp_pkg::t_reg_idx idx, input bit wr,
                              input logic [fwbp_pkg::DATA_W-1:0] wdata,
                              output logic [fwbp_pkg::DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input fwbp_pkg::t_reg_idx idx,
                             input logic [fwbp_pkg::DATA_W-1:0] v);
        logic [fwbp_pkg::DATA_W-1:0] rd;
        apb_access(idx, 1'b1, v, rd);
        apply_reg(idx, v);
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== (v & reg_mask(idx))) begin
            $error("%s readback expected %0h got %0h", idx.name(), v & reg_mask(idx), rd);
            fail_cnt++;
        end
        // period and start writes trigger a frame recompute that holds the base port off
        while (!base_if.ready) @(posedge i_clk);
    endtask

    // stop sending and let every outstanding result and queued base drain
    task automatic settle();
        base_if.valid <= 1'b0;
        while (profile_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_base(input logic [fwbp_pkg::CHAR_W-1:0] c);
        if (base_idle_on && $urandom_range(99) < 15) begin
            base_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        base_if.valid     <= 1'b1;
        base_if.base_char <= c;
        @(posedge i_clk);
        while (!base_if.ready) @(posedge i_clk);
        predict_base(c);
    endtask

    task automatic random_setup(input bit full_window);
        logic [fwbp_pkg::START_W-1:0] first_pos;
        if (full_window || $urandom_range(3) != 0) begin
            first_pos = fwbp_pkg::START_W'($urandom_range(5000));
        end else begin
            first_pos = fwbp_pkg::START_W'(28'hFFFFFFF - $urandom_range(40));
        end
        write_reg(fwbp_pkg::REG_BASE_SET, $urandom_range(15));
        write_reg(fwbp_pkg::REG_WINDOW_LEN,
                  full_window ? ($urandom_range(1) ? 256 : 511) : $urandom_range(16));
        write_reg(fwbp_pkg::REG_STEP_LEN,
                  full_window ? $urandom_range(20, 1) : $urandom_range(6));
        write_reg(fwbp_pkg::REG_PERIOD_LEN, $urandom_range(15));
        write_reg(fwbp_pkg::REG_START_POS, fwbp_pkg::DATA_W'(first_pos));
        if (!full_window && $urandom_range(4) == 0) begin
            write_reg(fwbp_pkg::REG_END_POS,
                      fwbp_pkg::DATA_W'(fwbp_pkg::START_W'(first_pos + $urandom_range(30, 5))));
        end else begin
            write_reg(fwbp_pkg::REG_END_POS, fwbp_pkg::DATA_W'({fwbp_pkg::START_W{1'b1}}));
        end
    endtask

    // every counted letter, off-set letters and junk bytes, single-base window
    task automatic test_base_codes();
        write_reg(fwbp_pkg::REG_BASE_SET, 15);
        write_reg(fwbp_pkg::REG_WINDOW_LEN, 1);
        write_reg(fwbp_pkg::REG_STEP_LEN, 1);
        write_reg(fwbp_pkg::REG_PERIOD_LEN, 1);
        write_reg(fwbp_pkg::REG_START_POS, 0);
        write_reg(fwbp_pkg::REG_END_POS, fwbp_pkg::DATA_W'({fwbp_pkg::START_W{1'b1}}));
        send_base(fwbp_pkg::CHAR_A);
        send_base(fwbp_pkg::CHAR_C);
        send_base(fwbp_pkg::CHAR_G);
        send_base(fwbp_pkg::CHAR_T);
        send_base(CHAR_LOWER_A);
        send_base(CHAR_U);
        send_base(CHAR_NUL);
        send_base(CHAR_ALL_ONE);
        settle();
        write_reg(fwbp_pkg::REG_BASE_SET, 0);
        write_reg(fwbp_pkg::REG_WINDOW_LEN, 0);
        send_base(fwbp_pkg::CHAR_G);
        send_base(fwbp_pkg::CHAR_C);
        settle();
    endtask

    // period above the cap, zero step, window not a multiple of the period
    task automatic test_frame_spread();
        write_reg(fwbp_pkg::REG_PERIOD_LEN, 15);
        write_reg(fwbp_pkg::REG_WINDOW_LEN, 2);
        write_reg(fwbp_pkg::REG_STEP_LEN, 0);
        write_reg(fwbp_pkg::REG_BASE_SET, 4'b0110);
        send_base(fwbp_pkg::CHAR_G);
        send_base(fwbp_pkg::CHAR_C);
        send_base(fwbp_pkg::CHAR_G);
        send_base(fwbp_pkg::CHAR_A);
        settle();
    endtask

    // top of the position range, bases past the end, clipped centre, oversized window
    task automatic test_position_edges();
        write_reg(fwbp_pkg::REG_BASE_SET, 4'b1001);
        write_reg(fwbp_pkg::REG_WINDOW_LEN, 4);
        write_reg(fwbp_pkg::REG_STEP_LEN, 1);
        write_reg(fwbp_pkg::REG_PERIOD_LEN, 3);
        write_reg(fwbp_pkg::REG_START_POS, fwbp_pkg::DATA_W'(28'hFFFFFFD));
        write_reg(fwbp_pkg::REG_END_POS, fwbp_pkg::DATA_W'({fwbp_pkg::START_W{1'b1}}));
        send_base(fwbp_pkg::CHAR_T);
        send_base(fwbp_pkg::CHAR_A);
        send_base(fwbp_pkg::CHAR_T);
        send_base(fwbp_pkg::CHAR_A);
        send_base(fwbp_pkg::CHAR_C);
        settle();
        write_reg(fwbp_pkg::REG_START_POS, 0);
        send_base(fwbp_pkg::CHAR_A);
        send_base(fwbp_pkg::CHAR_T);
        settle();
        write_reg(fwbp_pkg::REG_END_POS, 0);
        send_base(fwbp_pkg::CHAR_A);
        settle();
        write_reg(fwbp_pkg::REG_WINDOW_LEN, 511);
        write_reg(fwbp_pkg::REG_STEP_LEN, 65535);
        write_reg(fwbp_pkg::REG_END_POS, fwbp_pkg::DATA_W'({fwbp_pkg::START_W{1'b1}}));
        write_reg(fwbp_pkg::REG_START_POS, 0);
        send_base(fwbp_pkg::CHAR_C);
        send_base(fwbp_pkg::CHAR_G);
        settle();
    endtask

    task automatic test_random_mix();
        base_idle_on = 1'b1;
        res_idle_on  = 1'b1;
        repeat (4) begin
            random_setup(1'b0);
            repeat (12) send_base(rand_base());
            settle();
        end
    endtask

    task automatic test_steady_stream();
        base_idle_on = 1'b0;
        res_idle_on  = 1'b0;
        random_setup(1'b0);
        repeat (40) send_base(rand_base());
        settle();
    endtask

    task automatic test_drain_pause();
        base_idle_on = 1'b1;
        res_idle_on  = 1'b1;
        random_setup(1'b0);
        repeat (15) send_base(rand_base());
        settle();
        repeat (15) send_base(rand_base());
        settle();
    endtask

    task automatic test_full_window();
        random_setup(1'b1);
        repeat (270) send_base(rand_base());
        settle();
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        res_if.ready <= !(res_idle_on && $urandom_range(99) < 15);
    end

    always @(posedge i_clk) begin : check_results
        t_profile want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (profile_q.size() == 0) begin
                $error("unexpected result centre_pos %0d frame %0d count %0d",
                       res_if.centre_pos, res_if.frame, res_if.count);
                fail_cnt++;
            end else begin
                want = profile_q.pop_front();
                check_field("centre_pos", want.centre_pos, res_if.centre_pos);
                check_field("frame", want.frame, res_if.frame);
                check_field("count", want.count, res_if.count);
                check_field("last", want.last, res_if.last);
            end
        end
    end

    // any transfer on either stream or the register port counts as progress
    always @(posedge i_clk) begin
        if ((base_if.valid && base_if.ready) || (res_if.valid && res_if.ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        base_if.valid     <= 1'b0;
        base_if.base_char <= '0;
        clear_profile_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // flag ring clearing pass after reset
        while (!base_if.ready) @(posedge i_clk);
        test_base_codes();
        test_frame_spread();
        test_position_edges();
        test_random_mix();
        test_steady_stream();
        test_drain_pause();
        test_full_window();
        settle();
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
